### rtl/core/i2r_pkg.sv
`default_nettype none
package i2r_pkg;

	localparam int VALUE_W = 31;
	localparam int RADIX_W = 6;
	localparam int CHAR_W  = 7;
	localparam int CNT_W   = $clog2(VALUE_W);

	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
	localparam logic [CNT_W-1:0]   LAST_STEP   = CNT_W'(VALUE_W - 1);

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
	localparam logic [CHAR_W-1:0] CHAR_A     = 7'd65;
	localparam logic [RADIX_W-1:0] DEC_DIGITS = 6'd10;

	// controller -> datapath
	typedef struct packed {
		logic load;   // take a new value, clear remainder
		logic step;   // one restoring-division bit
		logic emit;   // move finished digit to output register
	} i2r_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic quot_zero;
	} i2r_stat_t;

	function automatic logic [CHAR_W-1:0] digit_to_char(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DEC_DIGITS) begin
			c = CHAR_ZERO + CHAR_W'(d);
		end else begin
			c = CHAR_A + CHAR_W'(d - DEC_DIGITS);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

### rtl/core/integer_to_radix_digits.sv
// Integer to radix digits: turns a non-negative 31-bit integer into ASCII
// digit characters in the base held in the radix register (2..36).
// Input stream: s_tdata[30:0] carries the value, one beat per integer.
// Output stream: one beat per digit, least significant digit first;
// m_tdata[6:0] is '0'-'9' or 'A'-'Z', m_tlast marks the most significant
// digit. Zero gives a single '0' beat with m_tlast set.
// Config: cfg_wen/cfg_wdata write the radix; values below 2 or above 36
// saturate. Write only while idle. Reset value is 10.
// Timing: each digit is one restoring long division, one quotient bit per
// cycle over all 31 quotient bits, then a load of the output register.
// The divider is the limiting unit. One item at a time: s_tready is high
// only between items.
// The output register lets the divider start on the next digit while a
// digit waits; if m_tready stays low the block holds the next finished
// digit and stops. Reset (arst_n low) drops any item in flight, clears
// m_tvalid and restores radix 10.
`default_nettype none
module integer_to_radix_digits (
	input  wire         clk,
	input  wire         arst_n,
	// radix register write
	input  wire         cfg_wen,
	input  wire  [5:0]  cfg_wdata,
	// input stream
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,   // [30:0] value, [31] zero
	// output stream
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [7:0]  m_tdata,   // [6:0] digit_char, [7] zero
	output logic        m_tlast    // last_digit
);
	import i2r_pkg::*;

	i2r_cmd_t           cmd;
	i2r_stat_t          stat;
	logic [CHAR_W-1:0]  digit_char;

	i2r_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	i2r_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.value      (s_tdata[VALUE_W-1:0]),
		.cmd        (cmd),
		.stat       (stat),
		.digit_char (digit_char),
		.last_digit (m_tlast)
	);

	// s_tdata[31] is padding and ignored
	assign m_tdata = {1'b0, digit_char};

endmodule
`default_nettype wire

### rtl/core/i2r_datapath.sv
`default_nettype none
module i2r_datapath (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_wen,
	input  wire  [i2r_pkg::RADIX_W-1:0]  cfg_wdata,
	input  wire  [i2r_pkg::VALUE_W-1:0]  value,
	input  wire  i2r_pkg::i2r_cmd_t      cmd,
	output i2r_pkg::i2r_stat_t           stat,
	output logic [i2r_pkg::CHAR_W-1:0]   digit_char,
	output logic                         last_digit
);
	import i2r_pkg::*;

	logic [RADIX_W-1:0] radix_q;
	logic [VALUE_W-1:0] quot_q;
	logic [RADIX_W-1:0] rem_q;
	logic [RADIX_W:0]   rem_shift;
	logic [RADIX_W:0]   rem_diff;
	logic               qbit;
	logic [RADIX_W-1:0] radix_sat;

	// base saturates into 2..36 at write time
	always_comb begin
		if (cfg_wdata < RADIX_MIN) begin
			radix_sat = RADIX_MIN;
		end else if (cfg_wdata > RADIX_MAX) begin
			radix_sat = RADIX_MAX;
		end else begin
			radix_sat = cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_wen) begin
			radix_q <= radix_sat;
		end
	end

	assign rem_shift = {rem_q, quot_q[VALUE_W-1]};
	assign rem_diff  = rem_shift - {1'b0, radix_q};
	assign qbit      = (rem_shift >= {1'b0, radix_q});

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			quot_q <= value;
			rem_q  <= '0;
		end else if (cmd.step) begin
			quot_q <= {quot_q[VALUE_W-2:0], qbit};
			rem_q  <= qbit ? rem_diff[RADIX_W-1:0] : rem_shift[RADIX_W-1:0];
		end else if (cmd.emit) begin
			rem_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			digit_char <= digit_to_char(rem_q);
			last_digit <= (quot_q == '0);
		end
	end

	assign stat.quot_zero = (quot_q == '0);

endmodule
`default_nettype wire

### rtl/core/i2r_ctrl.sv
`default_nettype none
module i2r_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire                   out_ready,
	input  wire  i2r_pkg::i2r_stat_t stat,
	output i2r_pkg::i2r_cmd_t     cmd
);
	import i2r_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_free;

	assign out_free = !out_valid || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd.load = (state_q == ST_IDLE) && in_valid;
		cmd.step = (state_q == ST_DIV);
		cmd.emit = (state_q == ST_EMIT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.emit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
					end
				end
				ST_DIV: begin
					if (cnt_q == LAST_STEP) begin
						state_q <= ST_EMIT;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= stat.quot_zero ? ST_IDLE : ST_DIV;
						cnt_q   <= '0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire
